### hw/rtl/assert_macros.svh
// Assertion macros used by the retransmit queue scheduler back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RQS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("retransmit queue scheduler assertion failed");
`define RQS_ASSERT_NEVER(label, clk, rst_n, expr) \
    `RQS_ASSERT(label, clk, rst_n, !(expr))
`else
`define RQS_ASSERT(label, clk, rst_n, prop)
`define RQS_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### hw/rtl/rqs_pkg.sv
// Package with the types and constants of the retransmit queue scheduler.
`timescale 1ns / 1ps
package rqs_pkg;

    localparam int QUEUE_SLOTS = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd5;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_SEND     = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic        channel;
        logic [31:0] value;
        logic [31:0] timeout;
        logic [9:0]  length;
        logic [15:0] payload_ref;
    } cmd_t;

endpackage

### hw/rtl/rqs_front.sv
// Command front end: accepts transactions, classifies them and queues them.
`timescale 1ns / 1ps
module rqs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic                channel,
    input  logic [31:0]         sequence_req,
    input  logic [31:0]         ack_value,
    input  logic [31:0]         timeout,
    input  logic [9:0]          length,
    input  logic [15:0]         payload_ref,
    input  logic [31:0]         now,
    output logic                cmd_valid,
    output rqs_pkg::cmd_t       cmd,
    input  logic                cmd_pop
);
    import rqs_pkg::*;

    cmd_t                cmdq_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  wr_ptr_reg;
    logic [CMDQ_AW-1:0]  wr_ptr_next;
    logic [CMDQ_AW-1:0]  rd_ptr_reg;
    logic [CMDQ_AW-1:0]  rd_ptr_next;
    logic [CMDQ_CW-1:0]  count_reg;
    logic [CMDQ_CW-1:0]  count_next;
    logic                push;
    cmd_t                new_cmd;

    assign busy      = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign push      = start && !busy && (operation != OP_UNUSED);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cmdq_reg[rd_ptr_reg];

    // Only the operand word that the operation needs is kept.
    always_comb
    begin
        new_cmd.op          = operation;
        new_cmd.channel     = channel;
        new_cmd.timeout     = timeout;
        new_cmd.length      = length;
        new_cmd.payload_ref = payload_ref;
        unique case (operation)
            OP_ENQUEUE: new_cmd.value = sequence_req;
            OP_ACK:     new_cmd.value = ack_value;
            default:    new_cmd.value = now;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmdq_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### hw/rtl/rqs_back.sv
// Command back end: slot table, ack tracking and the tick walker.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rqs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  rqs_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          cfg_valid,
    input  logic [7:0]    cfg_data,
    output logic          result_strobe,
    output logic [1:0]    kind,
    output logic [2:0]    slot,
    output logic          link,
    output logic [15:0]   buffer_ref,
    output logic [9:0]    byte_count,
    output logic          last
);
    import rqs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [31:0]             now_reg, now_next;
    logic [7:0]              retry_limit_reg;

    logic [QUEUE_SLOTS-1:0]  used_reg, used_next;
    logic [QUEUE_SLOTS-1:0]  link_reg, link_next;
    logic [31:0]             seq_reg [QUEUE_SLOTS];
    logic [31:0]             seq_next [QUEUE_SLOTS];
    logic [31:0]             last_send_reg [QUEUE_SLOTS];
    logic [31:0]             last_send_next [QUEUE_SLOTS];
    logic [7:0]              retries_reg [QUEUE_SLOTS];
    logic [7:0]              retries_next [QUEUE_SLOTS];
    logic [9:0]              len_reg [QUEUE_SLOTS];
    logic [15:0]             ref_reg [QUEUE_SLOTS];
    logic [31:0]             timeout_reg [QUEUE_SLOTS];
    logic [31:0]             acked_reg [2];
    logic [31:0]             acked_next [2];

    logic                    pend_valid_reg, pend_valid_next;
    logic [2:0]              pend_slot_reg, pend_slot_next;
    logic                    pend_link_reg, pend_link_next;
    logic [15:0]             pend_ref_reg, pend_ref_next;
    logic [9:0]              pend_len_reg, pend_len_next;

    logic                    res_strobe_reg, res_strobe_next;
    logic [1:0]              res_kind_reg, res_kind_next;
    logic [2:0]              res_slot_reg, res_slot_next;
    logic                    res_link_reg, res_link_next;
    logic [15:0]             res_ref_reg, res_ref_next;
    logic [9:0]              res_len_reg, res_len_next;
    logic                    res_last_reg, res_last_next;

    logic                    enq_write;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic [31:0]             cur_acked;
    logic [31:0]             elapsed;
    logic                    covered;
    logic                    due;
    logic                    drop;

    assign result_strobe = res_strobe_reg;
    assign kind          = res_kind_reg;
    assign slot          = res_slot_reg;
    assign link          = res_link_reg;
    assign buffer_ref    = res_ref_reg;
    assign byte_count    = res_len_reg;
    assign last          = res_last_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            if (!used_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign cur_acked = link_reg[idx_reg] ? acked_reg[1] : acked_reg[0];
    assign covered   = (cur_acked >= seq_reg[idx_reg]);
    assign elapsed   = now_reg - last_send_reg[idx_reg];
    assign due       = (last_send_reg[idx_reg] == '0) || (elapsed >= timeout_reg[idx_reg]);
    assign drop      = (retries_reg[idx_reg] > retry_limit_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        used_next       = used_reg;
        link_next       = link_reg;
        seq_next        = seq_reg;
        last_send_next  = last_send_reg;
        retries_next    = retries_reg;
        acked_next      = acked_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_link_next  = pend_link_reg;
        pend_ref_next   = pend_ref_reg;
        pend_len_next   = pend_len_reg;
        res_strobe_next = 1'b0;
        res_kind_next   = res_kind_reg;
        res_slot_next   = res_slot_reg;
        res_link_next   = res_link_reg;
        res_ref_next    = res_ref_reg;
        res_len_next    = res_len_reg;
        res_last_next   = res_last_reg;
        cmd_pop         = 1'b0;
        enq_write       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_ENQUEUE:
                        begin
                            res_strobe_next = 1'b1;
                            res_last_next   = 1'b1;
                            res_link_next   = cmd.channel;
                            res_ref_next    = cmd.payload_ref;
                            res_len_next    = cmd.length;
                            if (free_found)
                            begin
                                enq_write                = 1'b1;
                                used_next[free_idx]      = 1'b1;
                                link_next[free_idx]      = cmd.channel;
                                seq_next[free_idx]       = cmd.value;
                                last_send_next[free_idx] = '0;
                                retries_next[free_idx]   = '0;
                                res_kind_next            = KIND_ACCEPTED;
                                res_slot_next            = 3'(free_idx);
                            end
                            else
                            begin
                                res_kind_next = KIND_FULL;
                                res_slot_next = '0;
                            end
                        end
                        OP_ACK:
                        begin
                            if (cmd.value > acked_reg[cmd.channel])
                            begin
                                acked_next[cmd.channel] = cmd.value;
                            end
                            // Covered by the new maximum means covered by either operand.
                            for (int i = 0; i < QUEUE_SLOTS; i++)
                            begin
                                if (used_reg[i] && (link_reg[i] == cmd.channel) &&
                                    (seq_reg[i] != '0) &&
                                    ((seq_reg[i] <= cmd.value) ||
                                     (seq_reg[i] <= acked_reg[cmd.channel])))
                                begin
                                    used_next[i] = 1'b0;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            now_next   = cmd.value;
                            idx_next   = '0;
                            cnt_next   = '0;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (used_reg[idx_reg])
                begin
                    if (covered)
                    begin
                        used_next[idx_reg] = 1'b0;
                    end
                    else if (due)
                    begin
                        if (drop)
                        begin
                            used_next[idx_reg] = 1'b0;
                        end
                        else if (cnt_reg < CNT_W'(MAX_RESULTS))
                        begin
                            cnt_next                = cnt_reg + 1'b1;
                            last_send_next[idx_reg] = now_reg;
                            retries_next[idx_reg]   = retries_reg[idx_reg] + 8'd1;
                            // A held request goes out once a later one shows it is not last.
                            if (pend_valid_reg)
                            begin
                                res_strobe_next = 1'b1;
                                res_kind_next   = KIND_SEND;
                                res_slot_next   = pend_slot_reg;
                                res_link_next   = pend_link_reg;
                                res_ref_next    = pend_ref_reg;
                                res_len_next    = pend_len_reg;
                                res_last_next   = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_slot_next  = 3'(idx_reg);
                            pend_link_next  = link_reg[idx_reg];
                            pend_ref_next   = ref_reg[idx_reg];
                            pend_len_next   = len_reg[idx_reg];
                        end
                    end
                end
                if (idx_reg == SLOT_W'(QUEUE_SLOTS - 1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    res_strobe_next = 1'b1;
                    res_kind_next   = KIND_SEND;
                    res_slot_next   = pend_slot_reg;
                    res_link_next   = pend_link_reg;
                    res_ref_next    = pend_ref_reg;
                    res_len_next    = pend_len_reg;
                    res_last_next   = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            retry_limit_reg <= RETRY_LIMIT_RESET;
            used_reg        <= '0;
            link_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            res_strobe_reg  <= 1'b0;
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                seq_reg[i]       <= '0;
                last_send_reg[i] <= '0;
                retries_reg[i]   <= '0;
            end
            acked_reg[0] <= '0;
            acked_reg[1] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            link_reg       <= link_next;
            pend_valid_reg <= pend_valid_next;
            res_strobe_reg <= res_strobe_next;
            seq_reg        <= seq_next;
            last_send_reg  <= last_send_next;
            retries_reg    <= retries_next;
            acked_reg      <= acked_next;
            if (cfg_valid)
            begin
                retry_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        pend_slot_reg <= pend_slot_next;
        pend_link_reg <= pend_link_next;
        pend_ref_reg  <= pend_ref_next;
        pend_len_reg  <= pend_len_next;
        res_kind_reg  <= res_kind_next;
        res_slot_reg  <= res_slot_next;
        res_link_reg  <= res_link_next;
        res_ref_reg   <= res_ref_next;
        res_len_reg   <= res_len_next;
        res_last_reg  <= res_last_next;
        if (enq_write)
        begin
            len_reg[free_idx]     <= cmd.length;
            ref_reg[free_idx]     <= cmd.payload_ref;
            timeout_reg[free_idx] <= cmd.timeout;
        end
    end

    `RQS_ASSERT(a_last_not_mid_walk, clk, rst_n, res_strobe_reg && res_last_reg |-> $past(state_reg) != S_WALK)
    `RQS_ASSERT_NEVER(a_pend_in_idle, clk, rst_n, pend_valid_reg && (state_reg == S_IDLE))
    `RQS_ASSERT(a_accept_slot_used, clk, rst_n, res_strobe_reg && (res_kind_reg == KIND_ACCEPTED) |-> used_reg[res_slot_reg])
    `RQS_ASSERT(a_full_all_used, clk, rst_n, res_strobe_reg && (res_kind_reg == KIND_FULL) |-> &used_reg)

endmodule

### hw/rtl/retransmit_queue_scheduler.sv
// Top level of the retransmit queue scheduler.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low; up to two transactions wait in
// a command queue, and busy is high only while that queue is full. The slot table takes an
// enqueue or an ack in its idle state. A tick is taken in the idle state, then the walker
// examines the eight slots in turn through a single shared compare path, and a flush state
// delivers the final send request. Results appear in the cycle after the work that causes
// them, each for exactly one cycle with result_strobe high, and must be taken then, since
// the block cannot be stalled from the result side. An enqueue answers with exactly one
// result, a tick with one send request per due slot that is within the retry limit and no
// result when nothing is due, and an ack with none; last marks the final result of a
// transaction. The retry limit register is written through the cfg channel, which is always
// ready, and should only be written while the block is idle.
module retransmit_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic        channel,
    input  logic [31:0] sequence_req,
    input  logic [31:0] ack_value,
    input  logic [31:0] timeout,
    input  logic [9:0]  length,
    input  logic [15:0] payload_ref,
    input  logic [31:0] now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        result_strobe,
    output logic [1:0]  kind,
    output logic [2:0]  slot,
    output logic        link,
    output logic [15:0] buffer_ref,
    output logic [9:0]  byte_count,
    output logic        last
);
    import rqs_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    rqs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .channel      (channel),
        .sequence_req (sequence_req),
        .ack_value    (ack_value),
        .timeout      (timeout),
        .length       (length),
        .payload_ref  (payload_ref),
        .now          (now),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    rqs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .kind          (kind),
        .slot          (slot),
        .link          (link),
        .buffer_ref    (buffer_ref),
        .byte_count    (byte_count),
        .last          (last)
    );

endmodule

### test/tb.sv
// Self-checking testbench for the retransmit queue scheduler: slot table predictor and stimulus.
`timescale 1ns / 1ps

import rqs_pkg::*;

typedef struct packed {
    logic [1:0]  op;
    logic        ch;
    logic [31:0] seq;
    logic [31:0] ackv;
    logic [31:0] tmo;
    logic [9:0]  len;
    logic [15:0] pref;
    logic [31:0] tnow;
} sched_cmd_t;

typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic        link;
    logic [15:0] buffer_ref;
    logic [9:0]  byte_count;
    logic        last;
} reply_t;

class retx_scoreboard;
    bit          occupied   [QUEUE_SLOTS];
    bit          slot_chan  [QUEUE_SLOTS];
    bit [31:0]   slot_seqno [QUEUE_SLOTS];
    bit [9:0]    slot_bytes [QUEUE_SLOTS];
    bit [15:0]   slot_buf   [QUEUE_SLOTS];
    bit [31:0]   sent_at    [QUEUE_SLOTS];
    bit [7:0]    tries      [QUEUE_SLOTS];
    bit [31:0]   rto        [QUEUE_SLOTS];
    bit [31:0]   cum_ack    [2];
    bit [7:0]    retry_limit;
    reply_t      replies_due[$];
    int          errors;

    function new();
        int i;
        for (i = 0; i < QUEUE_SLOTS; i++)
        begin
            occupied[i]   = 1'b0;
            slot_chan[i]  = 1'b0;
            slot_seqno[i] = '0;
            slot_bytes[i] = '0;
            slot_buf[i]   = '0;
            sent_at[i]    = '0;
            tries[i]      = '0;
            rto[i]        = '0;
        end
        cum_ack[0]  = '0;
        cum_ack[1]  = '0;
        retry_limit = RETRY_LIMIT_RESET;
        errors      = 0;
    endfunction

    function int outstanding();
        return replies_due.size();
    endfunction

    function string describe(reply_t r);
        return $sformatf("kind %0d slot %0d link %0d ref %h count %0d last %0d",
                         r.kind, r.slot, r.link, r.buffer_ref, r.byte_count, r.last);
    endfunction

    function void note_command(sched_cmd_t c);
        int          i;
        int          sends;
        bit          placed;
        bit          have_prev;
        bit [31:0]   elapsed;
        reply_t      r;
        reply_t      prev;
        sends     = 0;
        placed    = 1'b0;
        have_prev = 1'b0;
        prev      = '0;
        case (c.op)
            OP_ENQUEUE:
            begin
                r = {KIND_FULL, 3'd0, c.ch, c.pref, c.len, 1'b1};
                for (i = 0; i < QUEUE_SLOTS; i++)
                begin
                    if (!placed && !occupied[i])
                    begin
                        occupied[i]   = 1'b1;
                        tries[i]      = '0;
                        sent_at[i]    = '0;
                        slot_chan[i]  = c.ch;
                        slot_seqno[i] = c.seq;
                        slot_bytes[i] = c.len;
                        slot_buf[i]   = c.pref;
                        rto[i]        = c.tmo;
                        r = {KIND_ACCEPTED, 3'(i), c.ch, c.pref, c.len, 1'b1};
                        placed = 1'b1;
                    end
                end
                replies_due.push_back(r);
            end
            OP_ACK:
            begin
                if (c.ackv > cum_ack[c.ch])
                    cum_ack[c.ch] = c.ackv;
                for (i = 0; i < QUEUE_SLOTS; i++)
                begin
                    if (occupied[i] && slot_chan[i] == c.ch && slot_seqno[i] != 0 &&
                        slot_seqno[i] <= cum_ack[c.ch])
                        occupied[i] = 1'b0;
                end
            end
            OP_TICK:
            begin
                for (i = 0; i < QUEUE_SLOTS; i++)
                begin
                    elapsed = c.tnow - sent_at[i];
                    if (!occupied[i])
                    begin
                    end
                    else if (cum_ack[slot_chan[i]] >= slot_seqno[i])
                        occupied[i] = 1'b0;
                    else if (sent_at[i] == 0 || elapsed >= rto[i])
                    begin
                        if (tries[i] > retry_limit)
                            occupied[i] = 1'b0;
                        else if (sends < MAX_RESULTS)
                        begin
                            if (have_prev)
                                replies_due.push_back(prev);
                            prev = {KIND_SEND, 3'(i), slot_chan[i], slot_buf[i],
                                    slot_bytes[i], 1'b0};
                            have_prev  = 1'b1;
                            sends++;
                            sent_at[i] = c.tnow;
                            tries[i]   = tries[i] + 8'd1;
                        end
                    end
                end
                if (have_prev)
                begin
                    prev.last = 1'b1;
                    replies_due.push_back(prev);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_reply(reply_t got);
        reply_t want;
        if (replies_due.size() == 0)
        begin
            errors++;
            if (errors <= 50)
                $display("%0t: unexpected reply, expected none, actual %s", $time, describe(got));
        end
        else
        begin
            want = replies_due.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot || got.link !== want.link ||
                got.buffer_ref !== want.buffer_ref || got.byte_count !== want.byte_count ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: reply mismatch, expected %s, actual %s",
                             $time, describe(want), describe(got));
            end
        end
    endfunction
endclass

module tb;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic        channel;
    logic [31:0] sequence_req;
    logic [31:0] ack_value;
    logic [31:0] timeout;
    logic [9:0]  length;
    logic [15:0] payload_ref;
    logic [31:0] now;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        result_strobe;
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic        link;
    logic [15:0] buffer_ref;
    logic [9:0]  byte_count;
    logic        last;

    retx_scoreboard sb;
    int             idle_cycles;
    int             burst_left;
    int unsigned    next_seq [2];
    int unsigned    clock_ms;

    retransmit_queue_scheduler dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_reply({kind, slot, link, buffer_ref, byte_count, last});
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic sched_cmd_t noise_fields();
        sched_cmd_t c;
        c.op   = 2'($urandom_range(0, 3));
        c.ch   = 1'($urandom_range(0, 1));
        c.seq  = $urandom;
        c.ackv = $urandom;
        c.tmo  = $urandom;
        c.len  = 10'($urandom_range(0, 1023));
        c.pref = 16'($urandom_range(0, 65535));
        c.tnow = $urandom;
        return c;
    endfunction

    function automatic sched_cmd_t enqueue_cmd(logic ch, logic [31:0] seq, logic [31:0] tmo,
                                               logic [9:0] len, logic [15:0] pref);
        sched_cmd_t c;
        c      = noise_fields();
        c.op   = OP_ENQUEUE;
        c.ch   = ch;
        c.seq  = seq;
        c.tmo  = tmo;
        c.len  = len;
        c.pref = pref;
        return c;
    endfunction

    function automatic sched_cmd_t ack_cmd(logic ch, logic [31:0] v);
        sched_cmd_t c;
        c      = noise_fields();
        c.op   = OP_ACK;
        c.ch   = ch;
        c.ackv = v;
        return c;
    endfunction

    function automatic sched_cmd_t tick_cmd(logic [31:0] t);
        sched_cmd_t c;
        c      = noise_fields();
        c.op   = OP_TICK;
        c.tnow = t;
        return c;
    endfunction

    task automatic issue(sched_cmd_t c);
        int gap;
        operation    <= c.op;
        channel      <= c.ch;
        sequence_req <= c.seq;
        ack_value    <= c.ackv;
        timeout      <= c.tmo;
        length       <= c.len;
        payload_ref  <= c.pref;
        now          <= c.tnow;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 14);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_retry_limit(logic [7:0] v);
        settle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.retry_limit = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int items);
        int          k;
        int          pick;
        logic        ch;
        logic [31:0] tmo;
        sched_cmd_t  c;
        for (k = 0; k < items; k++)
        begin
            pick = $urandom_range(0, 99);
            ch   = 1'($urandom_range(0, 1));
            if (pick < 36)
            begin
                next_seq[ch] += $urandom_range(1, 4);
                case ($urandom_range(0, 9))
                    0, 1:    tmo = 0;
                    2, 3:    tmo = $urandom_range(300, 2000);
                    4:       tmo = $urandom;
                    default: tmo = $urandom_range(1, 300);
                endcase
                issue(enqueue_cmd(ch, next_seq[ch], tmo, 10'($urandom_range(0, 1023)),
                                  16'($urandom_range(0, 65535))));
            end
            else if (pick < 56)
            begin
                if ($urandom_range(0, 9) == 0)
                    issue(ack_cmd(ch, $urandom_range(0, 15)));
                else
                    issue(ack_cmd(ch, next_seq[ch] - $urandom_range(0, 12)));
            end
            else if (pick < 95)
            begin
                clock_ms += $urandom_range(0, 200);
                issue(tick_cmd(clock_ms));
            end
            else
            begin
                c = noise_fields();
                if (c.op == OP_ACK)
                    c.ackv = c.ackv & 32'h1F;
                issue(c);
            end
        end
    endtask

    task automatic retry_wrap_phase();
        int i;
        set_retry_limit(8'd255);
        for (i = 0; i < QUEUE_SLOTS; i++)
        begin
            next_seq[i % 2] += 1;
            issue(enqueue_cmd(1'(i % 2), next_seq[i % 2], 32'd0, 10'($urandom_range(0, 1023)),
                              16'($urandom_range(0, 65535))));
        end
        for (i = 0; i < 258; i++)
        begin
            clock_ms += $urandom_range(1, 50);
            issue(tick_cmd(clock_ms));
        end
    endtask

    initial
    begin
        sb           = new();
        idle_cycles  = 0;
        burst_left   = 8;
        next_seq[0]  = 16;
        next_seq[1]  = 16;
        clock_ms     = 1000;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        operation    <= OP_ENQUEUE;
        channel      <= 1'b0;
        sequence_req <= '0;
        ack_value    <= '0;
        timeout      <= '0;
        length       <= '0;
        payload_ref  <= '0;
        now          <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(tick_cmd(32'd0));
        issue(noise_fields() | {OP_UNUSED, 155'd0});
        issue(enqueue_cmd(1'b0, 32'd0, 32'd0, 10'd0, 16'h0000));
        issue(enqueue_cmd(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF));
        issue(enqueue_cmd(1'b0, 32'd1, 32'd10, 10'd1, 16'h0001));
        issue(enqueue_cmd(1'b1, 32'd2, 32'd50, 10'd512, 16'h8000));
        issue(enqueue_cmd(1'b0, 32'd5, 32'd0, 10'd341, 16'h5555));
        issue(enqueue_cmd(1'b1, 32'd7, 32'd100, 10'd682, 16'hAAAA));
        issue(enqueue_cmd(1'b0, 32'd9, 32'd20, 10'd3, 16'h1234));
        issue(enqueue_cmd(1'b1, 32'd3, 32'd30, 10'd1000, 16'hFEDC));
        issue(enqueue_cmd(1'b1, 32'd11, 32'd5, 10'd1023, 16'hFFFF));
        issue(tick_cmd(32'd0));
        issue(tick_cmd(32'd0));
        issue(tick_cmd(32'd5));
        issue(tick_cmd(32'd15));
        issue(ack_cmd(1'b0, 32'd5));
        issue(ack_cmd(1'b0, 32'd0));
        issue(ack_cmd(1'b1, 32'd2));
        issue(enqueue_cmd(1'b0, 32'd0, 32'd1, 10'd7, 16'h0F0F));
        issue(tick_cmd(32'hFFFF_FFFF));
        issue(tick_cmd(32'd40));
        issue(tick_cmd(32'd80));
        issue(tick_cmd(32'd120));
        issue(tick_cmd(32'd160));

        random_phase(20);
        set_retry_limit(8'd0);
        random_phase(20);
        set_retry_limit(8'd254);
        random_phase(20);
        retry_wrap_phase();
        set_retry_limit(8'd2);
        random_phase(20);
        set_retry_limit(8'd1);
        random_phase(18);
        set_retry_limit(8'($urandom_range(0, 254)));
        random_phase(18);

        issue(ack_cmd(1'b0, 32'hFFFF_FFFF));
        issue(ack_cmd(1'b1, 32'hFFFF_FFFF));
        issue(enqueue_cmd(1'b0, $urandom, 32'd0, 10'($urandom_range(0, 1023)), 16'h0000));
        issue(enqueue_cmd(1'b1, $urandom, 32'd0, 10'($urandom_range(0, 1023)), 16'hFFFF));
        issue(tick_cmd($urandom));

        settle();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
